FILE: hdl/bdqs_pkg.sv
// Package for the bounded deque with search: field widths, operation and
// status codes, controller states. No dependencies.
package bdqs_pkg;

    // Default number of entries the deque can hold
    localparam int CAPACITY_DEF = 16;

    // Fixed payload widths
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes carried in the func field
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_BACK   = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_SEARCH     = 3'd4,
        FN_CLEAR      = 3'd5
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        SM_IDLE   = 1'b0,
        SM_SEARCH = 1'b1
    } state_t;

endpackage

FILE: hdl/bdqs_if.sv
// Valid/ready channel interfaces for the deque: request and result items.
// Depends on bdqs_pkg for payload widths.
interface bdqs_req_if;
    logic                                valid;
    logic                                ready;
    logic [bdqs_pkg::FUNC_W-1:0]         func;
    logic signed [bdqs_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface bdqs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bdqs_pkg::STATUS_W-1:0] status;
    logic                          found;
    logic [bdqs_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output found, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found, input entry_count,
                    output ready);
endinterface

FILE: hdl/bdqs_mem.sv
// Entry storage of the deque: one write port, one read port, registered read.
// Depends on bdqs_pkg for the value width.
module bdqs_mem #(
    parameter int DEPTH = bdqs_pkg::CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [bdqs_pkg::VALUE_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [bdqs_pkg::VALUE_W-1:0] rd_data
);

    logic [bdqs_pkg::VALUE_W-1:0] ram_reg [DEPTH];
    logic [bdqs_pkg::VALUE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/bdqs_ctrl.sv
// Deque controller: ring pointers, occupancy, search scan over the entry
// memory and the result register. Depends on bdqs_pkg and bdqs_if.
module bdqs_ctrl #(
    parameter int CAPACITY = bdqs_pkg::CAPACITY_DEF,
    parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bdqs_req_if.sink                      req,
    bdqs_rsp_if.source                    rsp,
    output logic                          mem_wr_en,
    output logic [IW-1:0]                 mem_wr_addr,
    output logic [bdqs_pkg::VALUE_W-1:0]  mem_wr_data,
    output logic                          mem_rd_en,
    output logic [IW-1:0]                 mem_rd_addr,
    input  logic [bdqs_pkg::VALUE_W-1:0]  mem_rd_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int XW = CW + bdqs_pkg::COUNT_W;

    bdqs_pkg::state_t state_reg, state_next;

    logic [IW-1:0]                 front_reg, front_next;
    logic [CW-1:0]                 occ_reg, occ_next;
    logic [IW-1:0]                 scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]                 scan_left_reg, scan_left_next;
    logic                          rd_pend_reg, rd_pend_next;
    logic                          hit_reg, hit_next;
    logic [bdqs_pkg::VALUE_W-1:0]  key_reg, key_next;

    logic                          out_valid_reg, out_valid_next;
    logic [bdqs_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic                          out_found_reg, out_found_next;
    logic [bdqs_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                          slot_free;
    logic                          req_ready;
    logic                          accept;
    logic                          is_full;
    logic                          is_empty;
    logic [IW-1:0]                 front_prev;
    logic [IW-1:0]                 front_succ;
    logic [IW-1:0]                 scan_succ;
    logic [SW-1:0]                 back_sum;
    logic [SW-1:0]                 back_pos;
    logic [IW-1:0]                 back_idx;
    logic                          scan_done;
    logic                          hit_now;
    logic                          res_load;
    logic [bdqs_pkg::STATUS_W-1:0] res_status;
    logic                          res_found;
    logic [XW-1:0]                 occ_wide;

    // Handshake and occupancy flags
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req_ready = (state_reg == bdqs_pkg::SM_IDLE) && slot_free;
    assign accept    = req.valid && req_ready;
    assign is_full   = (occ_reg == CW'(CAPACITY));
    assign is_empty  = (occ_reg == '0);

    // Ring position arithmetic, modulo CAPACITY
    assign front_prev = (front_reg == '0) ? IW'(CAPACITY - 1) : front_reg - 1'b1;
    assign front_succ = (front_reg == IW'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;
    assign scan_succ  = (scan_ptr_reg == IW'(CAPACITY - 1)) ? '0 : scan_ptr_reg + 1'b1;
    assign back_sum   = SW'(front_reg) + SW'(occ_reg);
    assign back_pos   = (back_sum >= SW'(CAPACITY)) ? back_sum - SW'(CAPACITY) : back_sum;
    assign back_idx   = back_pos[IW-1:0];

    // Scan status: compare lands in the cycle after its read is issued
    assign hit_now   = rd_pend_reg && (mem_rd_data == key_reg);
    assign scan_done = (state_reg == bdqs_pkg::SM_SEARCH) && (scan_left_reg == '0)
                       && !rd_pend_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdqs_pkg::SM_IDLE:
            begin
                if (accept && (req.func == bdqs_pkg::FN_SEARCH) && !is_empty)
                begin
                    state_next = bdqs_pkg::SM_SEARCH;
                end
            end
            bdqs_pkg::SM_SEARCH:
            begin
                if (scan_done && slot_free)
                begin
                    state_next = bdqs_pkg::SM_IDLE;
                end
            end
            default:
            begin
                state_next = bdqs_pkg::SM_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and result.
    // Writes happen only on accepts in idle and reads only while scanning,
    // so the two ports never touch the same entry in overlapping cycles.
    always_comb
    begin
        front_next     = front_reg;
        occ_next       = occ_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        rd_pend_next   = 1'b0;
        hit_next       = hit_reg;
        key_next       = key_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = back_idx;
        mem_wr_data    = req.value;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = scan_ptr_reg;
        res_load       = 1'b0;
        res_status     = bdqs_pkg::STAT_OK;
        res_found      = 1'b0;

        unique case (state_reg)
            bdqs_pkg::SM_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    unique case (req.func)
                        bdqs_pkg::FN_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                res_status = bdqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = back_idx;
                                occ_next    = occ_reg + 1'b1;
                            end
                        end
                        bdqs_pkg::FN_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                res_status = bdqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = front_prev;
                                front_next  = front_prev;
                                occ_next    = occ_reg + 1'b1;
                            end
                        end
                        bdqs_pkg::FN_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                res_status = bdqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        bdqs_pkg::FN_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_status = bdqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                front_next = front_succ;
                                occ_next   = occ_reg - 1'b1;
                            end
                        end
                        bdqs_pkg::FN_SEARCH:
                        begin
                            // empty deque answers at once, else start the scan
                            if (!is_empty)
                            begin
                                res_load       = 1'b0;
                                scan_ptr_next  = front_reg;
                                scan_left_next = occ_reg;
                                hit_next       = 1'b0;
                                key_next       = req.value;
                            end
                        end
                        bdqs_pkg::FN_CLEAR:
                        begin
                            front_next = '0;
                            occ_next   = '0;
                        end
                        default:
                        begin
                            // unused codes leave the deque as it is
                        end
                    endcase
                end
            end
            bdqs_pkg::SM_SEARCH:
            begin
                // issue one read per cycle, fold in the previous compare
                if (scan_left_reg != '0)
                begin
                    mem_rd_en      = 1'b1;
                    scan_ptr_next  = scan_succ;
                    scan_left_next = scan_left_reg - 1'b1;
                    rd_pend_next   = 1'b1;
                end
                hit_next = hit_reg | hit_now;
                if (scan_done && slot_free)
                begin
                    res_load  = 1'b1;
                    res_found = hit_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    assign occ_wide = XW'(occ_next);

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        if (res_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_found_next  = res_found;
            out_count_next  = occ_wide[bdqs_pkg::COUNT_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdqs_pkg::SM_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            scan_left_reg <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            scan_left_reg <= scan_left_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_ptr_reg   <= scan_ptr_next;
        hit_reg        <= hit_next;
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    assign req.ready       = req_ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.entry_count = out_count_reg;

endmodule

FILE: hdl/bounded_deque_with_search.sv
// Top level of the bounded deque with membership search.
// Depends on bdqs_pkg, bdqs_if, bdqs_mem and bdqs_ctrl.
//
//   Channel | Direction | Payload                          | Item
//   --------+-----------+----------------------------------+--------------------
//   req     | in        | func[2:0], value[31:0] signed    | one request
//   rsp     | out       | status[1:0], found, entry_count  | one result per req
//
// Push, pop, clear, unused codes and a search of an empty deque: result
// registered in the cycle after the item is taken; a new item can be taken every
// cycle while no result waits. Search of a non-empty deque: the single memory read
// port scans one entry per cycle; no new item is taken until the scan ends.
// Reset clears pointers and occupancy at once; entries need no clearing pass.
// A waiting result blocks the next item only while the sink holds ready low.
module bounded_deque_with_search #(
    parameter int CAPACITY = bdqs_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bdqs_req_if.sink   req,
    bdqs_rsp_if.source rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                         mem_wr_en;
    logic [IW-1:0]                mem_wr_addr;
    logic [bdqs_pkg::VALUE_W-1:0] mem_wr_data;
    logic                         mem_rd_en;
    logic [IW-1:0]                mem_rd_addr;
    logic [bdqs_pkg::VALUE_W-1:0] mem_rd_data;

    // Controller
    bdqs_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Entry storage
    bdqs_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

FILE: hdl/bdqs_check.sv
// Port-level checker for the bounded deque, bound to the top level.
// Depends on bdqs_pkg and bounded_deque_with_search.
module bdqs_check #(
    parameter int CAPACITY = bdqs_pkg::CAPACITY_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bdqs_pkg::STATUS_W-1:0] rsp_status,
    input logic                          rsp_found,
    input logic [bdqs_pkg::COUNT_W-1:0]  rsp_entry_count
);

    logic [1:0] pend_reg, pend_next;
    logic       in_acc;
    logic       out_acc;

    // Items taken but not yet answered
    assign in_acc  = req_valid && req_ready;
    assign out_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_found) && $stable(rsp_entry_count))
        else $error("result changed while stalled");

    // Exactly one item in flight whenever a result is shown
    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg == 2'd1)
        else $error("result without exactly one pending item");

    // Only a successful search reports a hit
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_status == bdqs_pkg::STAT_OK)
        else $error("found set with error status");

    // Full status only with a full deque
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == bdqs_pkg::STAT_FULL
            |-> rsp_entry_count == bdqs_pkg::COUNT_W'(CAPACITY))
        else $error("full status with wrong count");

    // Empty status only with an empty deque
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == bdqs_pkg::STAT_EMPTY |-> rsp_entry_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind bounded_deque_with_search bdqs_check #(
    .CAPACITY (CAPACITY)
) u_bdqs_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found       (rsp.found),
    .rsp_entry_count (rsp.entry_count)
);

FILE: test/bounded_deque_with_search_tb.sv
// Testbench for bounded_deque_with_search: directed and random requests,
// with an in-bench deque tracker that predicts every result and checks it.
// Depends on bdqs_pkg, bdqs_if and the block's RTL.
module bounded_deque_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = bdqs_pkg::CAPACITY_DEF;
    localparam int RSP_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES     = DEPTH + 8;
    localparam int IDLE_LIMIT      = 2000;

    // Codes that the block treats as no operation
    localparam logic [bdqs_pkg::FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [bdqs_pkg::FUNC_W-1:0] FN_SPARE7 = 3'd7;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } burst_t;

    typedef struct packed {
        bdqs_pkg::status_t            status;
        logic                         found;
        logic [bdqs_pkg::COUNT_W-1:0] entry_count;
    } deque_result_t;

    // Mirror of the deque contents plus the results still owed by the block
    class deque_tracker;
        logic signed [bdqs_pkg::VALUE_W-1:0] stored[$];
        deque_result_t                       pending_results[$];
        int                                  mismatches = 0;

        function void take_request(logic [bdqs_pkg::FUNC_W-1:0] code,
                                   logic signed [bdqs_pkg::VALUE_W-1:0] operand);
            deque_result_t outcome;
            outcome.status = bdqs_pkg::STAT_OK;
            outcome.found  = 1'b0;
            case (code)
                bdqs_pkg::FN_PUSH_BACK:
                    if (stored.size() >= DEPTH)
                        outcome.status = bdqs_pkg::STAT_FULL;
                    else
                        stored.push_back(operand);
                bdqs_pkg::FN_PUSH_FRONT:
                    if (stored.size() >= DEPTH)
                        outcome.status = bdqs_pkg::STAT_FULL;
                    else
                        stored.push_front(operand);
                bdqs_pkg::FN_POP_BACK:
                    if (stored.size() == 0)
                        outcome.status = bdqs_pkg::STAT_EMPTY;
                    else
                        void'(stored.pop_back());
                bdqs_pkg::FN_POP_FRONT:
                    if (stored.size() == 0)
                        outcome.status = bdqs_pkg::STAT_EMPTY;
                    else
                        void'(stored.pop_front());
                bdqs_pkg::FN_SEARCH:
                    foreach (stored[i])
                        if (stored[i] == operand)
                            outcome.found = 1'b1;
                bdqs_pkg::FN_CLEAR:
                    stored.delete();
                default:
                    ;
            endcase
            outcome.entry_count = bdqs_pkg::COUNT_W'(stored.size());
            pending_results.push_back(outcome);
        endfunction

        function void check_result(logic [bdqs_pkg::STATUS_W-1:0] status, logic found,
                                   logic [bdqs_pkg::COUNT_W-1:0] entry_count);
            deque_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d found %0b count %0d",
                         $time, status, found, entry_count);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                mismatches++;
            end
            if (found !== want.found)
            begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, found);
                mismatches++;
            end
            if (entry_count !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, entry_count);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic steady = 1'b0;
    int   hold_orders = 0;
    int   idle_cycles = 0;

    deque_tracker tracker = new();

    bdqs_req_if req_ch ();
    bdqs_rsp_if rsp_ch ();

    bounded_deque_with_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Result side: random stalls, a quiet window, and long holds on request
    initial
    begin
        int hold_left;
        int holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_taken != hold_orders)
            begin
                holds_taken = hold_orders;
                hold_left   = RSP_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_result(rsp_ch.status, rsp_ch.found, rsp_ch.entry_count);
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request, with an occasional gap first; return once accepted
    task automatic send_request(input logic [bdqs_pkg::FUNC_W-1:0] code,
                                input logic signed [bdqs_pkg::VALUE_W-1:0] operand);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 12)
            gap = $urandom_range(1, 3);
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.func  <= code;
        req_ch.value <= operand;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.take_request(code, operand);
    endtask

    // Stop offering and wait for every owed result
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [bdqs_pkg::FUNC_W-1:0] pick_func(burst_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            BURST_FILL:
                if (r < 42)      return bdqs_pkg::FN_PUSH_BACK;
                else if (r < 84) return bdqs_pkg::FN_PUSH_FRONT;
                else if (r < 94) return bdqs_pkg::FN_SEARCH;
                else if (r < 97) return bdqs_pkg::FN_POP_BACK;
                else             return bdqs_pkg::FN_POP_FRONT;
            BURST_DRAIN:
                if (r < 38)      return bdqs_pkg::FN_POP_BACK;
                else if (r < 76) return bdqs_pkg::FN_POP_FRONT;
                else if (r < 88) return bdqs_pkg::FN_SEARCH;
                else if (r < 94) return bdqs_pkg::FN_PUSH_BACK;
                else             return bdqs_pkg::FN_PUSH_FRONT;
            default:
                if (r < 20)      return bdqs_pkg::FN_PUSH_BACK;
                else if (r < 40) return bdqs_pkg::FN_PUSH_FRONT;
                else if (r < 55) return bdqs_pkg::FN_POP_BACK;
                else if (r < 70) return bdqs_pkg::FN_POP_FRONT;
                else if (r < 92) return bdqs_pkg::FN_SEARCH;
                else if (r < 96) return bdqs_pkg::FN_CLEAR;
                else if (r < 98) return FN_SPARE6;
                else             return FN_SPARE7;
        endcase
    endfunction

    // Searches mostly look for stored values; small values give duplicates
    function automatic logic signed [bdqs_pkg::VALUE_W-1:0] pick_value(
        logic [bdqs_pkg::FUNC_W-1:0] code);
        int r;
        r = $urandom_range(0, 99);
        if (code == bdqs_pkg::FN_SEARCH && tracker.stored.size() > 0 && r < 55)
            return tracker.stored[$urandom_range(0, tracker.stored.size() - 1)];
        if (r < 75)
            return $urandom;
        return $signed($urandom_range(0, 8)) - 4;
    endfunction

    task automatic run_random(input int count);
        burst_t                      mode;
        int                          left;
        logic [bdqs_pkg::FUNC_W-1:0] code;
        mode = BURST_MIXED;
        left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (left == 0)
            begin
                mode = burst_t'($urandom_range(0, 2));
                left = $urandom_range(6, 24);
            end
            left--;
            steady = (n >= 400 && n < 560);
            code = pick_func(mode);
            send_request(code, pick_value(code));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        logic signed [bdqs_pkg::VALUE_W-1:0] tail_value;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = '0;
        req_ch.value = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty queue: pops and a search
        send_request(bdqs_pkg::FN_POP_BACK, $urandom);
        send_request(bdqs_pkg::FN_POP_FRONT, $urandom);
        send_request(bdqs_pkg::FN_SEARCH, $urandom);
        // Extremes at both ends, found at both ends
        send_request(bdqs_pkg::FN_PUSH_BACK, 32'sh7FFF_FFFF);
        send_request(bdqs_pkg::FN_PUSH_FRONT, 32'sh8000_0000);
        send_request(bdqs_pkg::FN_SEARCH, 32'sh8000_0000);
        send_request(bdqs_pkg::FN_SEARCH, 32'sh7FFF_FFFF);
        // Fill up, then push on a full queue from both sides
        tail_value = '0;
        repeat (DEPTH - 2)
        begin
            tail_value = $urandom;
            send_request(bdqs_pkg::FN_PUSH_BACK, tail_value);
        end
        send_request(bdqs_pkg::FN_PUSH_BACK, $urandom);
        send_request(bdqs_pkg::FN_PUSH_FRONT, $urandom);
        send_request(bdqs_pkg::FN_SEARCH, tail_value);
        // Unused codes leave the queue alone
        send_request(FN_SPARE6, $urandom);
        send_request(FN_SPARE7, $urandom);
        send_request(bdqs_pkg::FN_POP_BACK, $urandom);
        send_request(bdqs_pkg::FN_POP_FRONT, $urandom);
        send_request(bdqs_pkg::FN_SEARCH, tail_value);
        send_request(bdqs_pkg::FN_CLEAR, $urandom);
        send_request(bdqs_pkg::FN_SEARCH, 32'sh8000_0000);
        wait_drained();

        // Result side holds off while requests keep coming
        steady = 1'b1;
        hold_orders++;
        repeat (30)
            send_request(pick_func(BURST_FILL), pick_value(bdqs_pkg::FN_PUSH_BACK));
        steady = 1'b0;

        run_random(990);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
